@@ rtl/udpck_pkg.sv @@
package udpck_pkg;

  // Largest packet the buffer takes, header included.
  localparam int unsigned MAX_PACKET_BYTES = 1500;
  localparam int unsigned HDR_BYTES        = 8;
  localparam int unsigned PROTO_UDP        = 17;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned OFFSET_W = 11;
  // Offsets and lengths before saturation need one bit above the count.
  localparam int unsigned LEN_W    = COUNT_W + 1;
  // Six 16-bit header words plus the protocol number.
  localparam int unsigned HSUM_W   = WORD_W + 3;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PACKET_BYTES);
  localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HDR_BYTES);
  localparam logic [HSUM_W-1:0] PROTO_W = HSUM_W'(PROTO_UDP);

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index, taken from the word address bit of paddr.
  typedef enum logic [0:0] {
    REG_LOCAL_ADDRESS = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_index_t;

endpackage

@@ rtl/udp_datagram_checksum_builder_top.sv @@
// A beat accepted at the input passes the input register, then the result register, to out_valid.
// Throughput: one beat per cycle while in_stall is low; an input register and a result register
//   part the two sides, so a new beat is taken while a finished result waits, and in_stall
//   rises only when both hold.
// The per-beat work is one add into the running sum plus, on the last beat, the final fold.
// Reset (rst, synchronous, active high) clears both valid flags, the datagram state and
//   local_address; payload registers are not reset.
module udp_datagram_checksum_builder_top (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [udpck_pkg::PADDR_W-1:0]     paddr,
  input  logic [udpck_pkg::PDATA_W-1:0]     pwdata,
  output logic [udpck_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [udpck_pkg::BYTE_W-1:0]      payload_byte,
  input  logic                              byte_present,
  input  logic                              last_item,
  input  logic [udpck_pkg::ADDR_W-1:0]      dest_address,
  input  logic [udpck_pkg::WORD_W-1:0]      dest_port_in,
  input  logic [udpck_pkg::WORD_W-1:0]      source_port_in,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [udpck_pkg::OFFSET_W-1:0]    write_offset,
  output logic [udpck_pkg::BYTE_W-1:0]      write_data,
  output logic                              write_valid,
  output logic                              datagram_done,
  output logic                              too_long,
  output logic [udpck_pkg::OFFSET_W-1:0]    udp_length,
  output logic [udpck_pkg::WORD_W-1:0]      checksum_value,
  output logic [udpck_pkg::WORD_W-1:0]      header_source_port,
  output logic [udpck_pkg::WORD_W-1:0]      header_dest_port
);

  // ---------------------------------------------------------------------------
  // Configuration register. Only one register exists; paddr bit 2 selects it,
  // the byte lane bits are ignored.
  // ---------------------------------------------------------------------------
  logic [udpck_pkg::ADDR_W-1:0] local_address;
  logic                         cfg_write;
  udpck_pkg::reg_index_t        cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = udpck_pkg::reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        udpck_pkg::REG_LOCAL_ADDRESS: local_address <= pwdata;
        default: local_address <= local_address;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      udpck_pkg::REG_LOCAL_ADDRESS: prdata = local_address;
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. Besides the beat itself it holds the sum of the header
  // words that are known on arrival: both addresses, both ports and the
  // protocol number. It is only used if the beat opens a datagram, and it
  // keeps that wide add out of the accumulate path.
  // ---------------------------------------------------------------------------
  logic                            s1_valid;
  logic [udpck_pkg::BYTE_W-1:0]    s1_byte;
  logic                            s1_present;
  logic                            s1_last;
  logic [udpck_pkg::ADDR_W-1:0]    s1_dest_address;
  logic [udpck_pkg::WORD_W-1:0]    s1_dest_port;
  logic [udpck_pkg::WORD_W-1:0]    s1_source_port;
  logic [udpck_pkg::HSUM_W-1:0]    s1_hdr_sum;
  logic [udpck_pkg::HSUM_W-1:0]    hdr_sum_next;

  logic in_accept;
  logic s1_adv;

  // The input register moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign s1_adv    = s1_valid && !(out_valid && out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign hdr_sum_next = udpck_pkg::HSUM_W'(local_address[31:16])
                      + udpck_pkg::HSUM_W'(local_address[15:0])
                      + udpck_pkg::HSUM_W'(dest_address[31:16])
                      + udpck_pkg::HSUM_W'(dest_address[15:0])
                      + udpck_pkg::HSUM_W'(source_port_in)
                      + udpck_pkg::HSUM_W'(dest_port_in)
                      + udpck_pkg::PROTO_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte         <= payload_byte;
      s1_present      <= byte_present;
      s1_last         <= last_item;
      s1_dest_address <= dest_address;
      s1_dest_port    <= dest_port_in;
      s1_source_port  <= source_port_in;
      s1_hdr_sum      <= hdr_sum_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Datagram state.
  // ---------------------------------------------------------------------------
  logic [udpck_pkg::SUM_W-1:0]     running_sum;
  logic [udpck_pkg::BYTE_W-1:0]    pending_high_byte;
  logic                            odd_byte_flag;
  logic [udpck_pkg::COUNT_W-1:0]   byte_count;
  logic                            in_datagram;
  logic [udpck_pkg::ADDR_W-1:0]    latched_dest_address;
  logic [udpck_pkg::WORD_W-1:0]    latched_dest_port;
  logic [udpck_pkg::WORD_W-1:0]    latched_source_port;
  logic                            overflow_flag;

  logic [udpck_pkg::SUM_W-1:0]     running_sum_next;
  logic [udpck_pkg::BYTE_W-1:0]    pending_high_byte_next;
  logic                            odd_byte_flag_next;
  logic [udpck_pkg::COUNT_W-1:0]   byte_count_next;
  logic [udpck_pkg::ADDR_W-1:0]    latched_dest_address_next;
  logic [udpck_pkg::WORD_W-1:0]    latched_dest_port_next;
  logic [udpck_pkg::WORD_W-1:0]    latched_source_port_next;
  logic                            overflow_flag_next;

  // Values as seen by this beat: a beat that opens a datagram starts from a
  // cleared state and from the header sum it brought along.
  logic                            start;
  logic [udpck_pkg::SUM_W-1:0]     base_sum;
  logic [udpck_pkg::BYTE_W-1:0]    base_pend;
  logic                            base_odd;
  logic [udpck_pkg::COUNT_W-1:0]   base_count;
  logic                            base_ovf;

  logic [udpck_pkg::LEN_W-1:0]     offset;
  logic                            byte_ok;
  logic [udpck_pkg::LEN_W-1:0]     len_full;
  logic [udpck_pkg::LEN_W-1:0]     len_sat;
  logic [udpck_pkg::SUM_W-1:0]     pad_word;
  logic [udpck_pkg::SUM_W-1:0]     total;
  logic [udpck_pkg::WORD_W:0]      fold1;
  logic [udpck_pkg::WORD_W:0]      fold2;
  logic [udpck_pkg::WORD_W-1:0]    csum;

  always_comb begin
    start      = !in_datagram;
    base_sum   = start ? udpck_pkg::SUM_W'(s1_hdr_sum) : running_sum;
    base_pend  = start ? '0 : pending_high_byte;
    base_odd   = start ? 1'b0 : odd_byte_flag;
    base_count = start ? '0 : byte_count;
    base_ovf   = start ? 1'b0 : overflow_flag;

    latched_dest_address_next = start ? s1_dest_address : latched_dest_address;
    latched_dest_port_next    = start ? s1_dest_port    : latched_dest_port;
    latched_source_port_next  = start ? s1_source_port  : latched_source_port;

    // A byte whose offset would reach the maximum is dropped, and so is
    // every byte after it in the same datagram.
    offset             = udpck_pkg::HDR_LEN + udpck_pkg::LEN_W'(base_count);
    byte_ok            = s1_present && !base_ovf && (offset < udpck_pkg::MAX_LEN);
    overflow_flag_next = base_ovf || (s1_present && !byte_ok);

    // Bytes pair up big-endian: the first of a pair waits as the high byte.
    running_sum_next       = base_sum;
    pending_high_byte_next = base_pend;
    odd_byte_flag_next     = base_odd;
    if (byte_ok) begin
      if (base_odd) begin
        running_sum_next = base_sum + udpck_pkg::SUM_W'({base_pend, s1_byte});
      end else begin
        pending_high_byte_next = s1_byte;
      end
      odd_byte_flag_next = !base_odd;
    end

    // The count keeps going past the maximum and saturates at all ones.
    byte_count_next = base_count;
    if (s1_present && (base_count != '1)) begin
      byte_count_next = base_count + 1'b1;
    end

    len_full = udpck_pkg::HDR_LEN + udpck_pkg::LEN_W'(byte_count_next);
    len_sat  = (len_full > udpck_pkg::MAX_LEN) ? udpck_pkg::MAX_LEN : len_full;

    // Final sum: payload words, an odd trailing byte padded with zero, and the
    // length twice (once in the pseudo-header, once in the UDP header).
    pad_word = odd_byte_flag_next
             ? udpck_pkg::SUM_W'({pending_high_byte_next, 8'h00}) : '0;
    total    = running_sum_next + pad_word
             + udpck_pkg::SUM_W'(len_sat) + udpck_pkg::SUM_W'(len_sat);

    // Two end-around folds bring any value of this range down to 16 bits.
    fold1 = (udpck_pkg::WORD_W + 1)'(total[15:0])
          + (udpck_pkg::WORD_W + 1)'(total[31:16]);
    fold2 = (udpck_pkg::WORD_W + 1)'(fold1[15:0])
          + (udpck_pkg::WORD_W + 1)'(fold1[16]);
    csum  = ~fold2[15:0];
    // A computed zero goes out as all ones, since zero means no checksum.
    if (csum == '0) begin
      csum = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum          <= '0;
      pending_high_byte    <= '0;
      odd_byte_flag        <= 1'b0;
      byte_count           <= '0;
      in_datagram          <= 1'b0;
      overflow_flag        <= 1'b0;
      latched_dest_address <= '0;
      latched_dest_port    <= '0;
      latched_source_port  <= '0;
    end else if (s1_adv) begin
      latched_dest_address <= latched_dest_address_next;
      latched_dest_port    <= latched_dest_port_next;
      latched_source_port  <= latched_source_port_next;
      if (s1_last) begin
        running_sum       <= '0;
        pending_high_byte <= '0;
        odd_byte_flag     <= 1'b0;
        byte_count        <= '0;
        in_datagram       <= 1'b0;
        overflow_flag     <= 1'b0;
      end else begin
        running_sum       <= running_sum_next;
        pending_high_byte <= pending_high_byte_next;
        odd_byte_flag     <= odd_byte_flag_next;
        byte_count        <= byte_count_next;
        in_datagram       <= 1'b1;
        overflow_flag     <= overflow_flag_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Fields that do not apply to a beat are sent as zero.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      write_offset       <= byte_ok ? offset[udpck_pkg::OFFSET_W-1:0] : '0;
      write_data         <= byte_ok ? s1_byte : '0;
      write_valid        <= byte_ok;
      datagram_done      <= s1_last;
      too_long           <= overflow_flag_next;
      udp_length         <= s1_last ? len_sat[udpck_pkg::OFFSET_W-1:0] : '0;
      checksum_value     <= (s1_last && !overflow_flag_next) ? csum : '0;
      header_source_port <= s1_last ? latched_source_port_next : '0;
      header_dest_port   <= s1_last ? latched_dest_port_next : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // A stored byte always lands between the header and the packet limit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |->
      ((udpck_pkg::LEN_W'(write_offset) >= udpck_pkg::HDR_LEN) &&
       (udpck_pkg::LEN_W'(write_offset) < udpck_pkg::MAX_LEN)))
    else $error("byte write outside the packet payload area");

  // A good datagram never reports the reserved zero checksum.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && datagram_done && !too_long) |-> (checksum_value != '0))
    else $error("zero checksum reported for a complete datagram");

  // Closing a datagram leaves a clean state for the next one.
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=>
      (!in_datagram && (running_sum == '0) && (byte_count == '0) && !overflow_flag))
    else $error("datagram state not cleared after the last beat");

  // An overflow marks the datagram as too long on every later result.
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && in_datagram && overflow_flag) |=> too_long)
    else $error("overflow flag lost within a datagram");
`endif

endmodule
